>>> rtl/core/gamma_ramp_entry_generator_top_macros.svh
// Assertion macros for the gamma ramp entry generator checker.
`ifndef GAMMA_RAMP_ENTRY_GENERATOR_TOP_MACROS_SVH
`define GAMMA_RAMP_ENTRY_GENERATOR_TOP_MACROS_SVH

// Property checked on every rising clk_i edge outside reset.
`define GRG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Signal holds its value while the output request is stalled.
`define GRG_ASSERT_HOLD(label, sig, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (m_axis_tvalid && !m_axis_tready) |=> $stable(sig)) else $error(msg);

`endif

>>> rtl/core/grg_pkg.sv
// Shared types, constants and elaboration-time tables for the gamma ramp generator.
`default_nettype none
package grg_pkg;

  localparam int unsigned IdxW     = 8;
  localparam int unsigned GammaW   = 10;
  localparam int unsigned ValW     = 16;
  localparam int unsigned LogW     = 36;   // unsigned log2, 32 fraction bits
  localparam int unsigned LgW      = 38;   // signed log2 difference
  localparam int unsigned YW       = 49;   // signed exponent * log2 product
  localparam int unsigned FracW    = 32;
  localparam int unsigned RW       = 32;   // Q1.31 mantissa
  localparam int unsigned ExpSteps = 32;
  localparam int unsigned Entries  = 256;
  localparam logic [10:0] ExpBias  = 11'd640;
  localparam logic [RW-1:0] OneQ31 = 32'h8000_0000;
  localparam logic [4:0]  MaxShift = 5'd16;
  localparam logic [GammaW-1:0] GammaReset = 10'd128;

  typedef logic [Entries-1:0][LogW-1:0] grg_log_tab_t;
  typedef logic [ExpSteps-1:0][RW-1:0]  grg_exp_tab_t;

  // Payload travelling through the exp2 product chain.
  typedef struct packed {
    logic            sat;   // result is full scale
    logic            zero;  // result underflows to zero
    logic [4:0]      k;     // integer part of -y
    logic [FracW-1:0] f;    // fraction of -y
    logic [RW-1:0]   r;     // running product 2^-f
  } grg_exp_t;

  function automatic logic [63:0] grg_isqrt(input logic [63:0] a);
    logic [63:0] rem;
    logic [63:0] r;
    logic [63:0] bitv;
    rem  = a;
    r    = '0;
    bitv = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= r + bitv) begin
        rem = rem - (r + bitv);
        r   = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  function automatic logic [LogW-1:0] grg_log2_q32(input int unsigned v);
    logic [63:0] x;
    logic [31:0] frac;
    int unsigned k;
    k    = 0;
    frac = '0;
    if (v == 0) return '0;
    for (int i = 0; i < 30; i++) begin
      if ((v >> (k + 1)) != 0) k++;
    end
    x = 64'(v) << (31 - k);
    for (int j = 31; j >= 0; j--) begin
      x = (x * x) >> 31;
      if (x >= 64'h1_0000_0000) begin
        x       = x >> 1;
        frac[j] = 1'b1;
      end
    end
    return (LogW'(k) << 32) | LogW'(frac);
  endfunction

  function automatic grg_log_tab_t grg_build_log_tab();
    grg_log_tab_t tab;
    for (int i = 0; i < Entries; i++) tab[i] = grg_log2_q32(i + 1);
    return tab;
  endfunction

  // Factors 2^(-2^-j), j = 1..32, by repeated square roots from one half.
  function automatic grg_exp_tab_t grg_build_exp_tab();
    grg_exp_tab_t tab;
    logic [63:0] t;
    t = 64'h4000_0000;
    for (int j = 0; j < ExpSteps; j++) begin
      t      = grg_isqrt(t << 31);
      tab[j] = t[RW-1:0];
    end
    return tab;
  endfunction

  localparam grg_log_tab_t LogTab = grg_build_log_tab();
  localparam grg_exp_tab_t ExpTab = grg_build_exp_tab();

endpackage
`default_nettype wire

>>> rtl/core/grg_front.sv
// Front stages: log2 lookup, exponent multiply, split of -y into integer and fraction.
`default_nettype none
module grg_front #(
  parameter int unsigned RampEntries = 256
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [grg_pkg::GammaW-1:0]   gamma_i,
  input  wire logic                         in_valid_i,
  input  wire logic [grg_pkg::IdxW-1:0]     in_idx_i,
  output logic                              in_ready_o,
  output logic                              out_valid_o,
  output grg_pkg::grg_exp_t                 out_data_o,
  input  wire logic                         out_ready_i
);
  import grg_pkg::*;

  localparam logic signed [LgW-1:0] LogBase = LgW'(grg_log2_q32(RampEntries));

  logic                     va_q, vb_q, vc_q;
  logic                     en_a, en_b, en_c;
  logic signed [LgW-1:0]    lg_q;
  logic signed [YW-1:0]     y_q;
  logic signed [10:0]       expo;
  logic [YW-1:0]            ny;
  logic [6:0]               kk;
  grg_exp_t                 c_d, c_q;

  assign en_c       = !vc_q || out_ready_i;
  assign en_b       = !vb_q || en_c;
  assign en_a       = !va_q || en_b;
  assign in_ready_o = en_a;

  assign expo = $signed(ExpBias) - $signed({1'b0, gamma_i});

  always_comb begin
    ny     = YW'(-y_q);
    kk     = ny[YW-2:41];
    c_d.sat  = !y_q[YW-1];
    c_d.zero = (kk > 7'(MaxShift));
    c_d.k    = kk[4:0];
    c_d.f    = ny[40:9];
    c_d.r    = OneQ31;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (en_a) va_q <= in_valid_i;
      if (en_b) vb_q <= va_q;
      if (en_c) vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) lg_q <= $signed({2'b00, LogTab[in_idx_i]}) - LogBase;
    if (en_b) y_q  <= YW'(expo * lg_q);
    if (en_c) c_q  <= c_d;
  end

  assign out_valid_o = vc_q;
  assign out_data_o  = c_q;
endmodule
`default_nettype wire

>>> rtl/core/grg_exp_step.sv
// One stage of the exp2 product chain: multiply by 2^(-2^-Step) when that fraction bit is set.
`default_nettype none
module grg_exp_step #(
  parameter int unsigned Step = 1
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire grg_pkg::grg_exp_t in_data_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output grg_pkg::grg_exp_t out_data_o,
  input  wire logic        out_ready_i
);
  import grg_pkg::*;

  localparam int unsigned BitIdx = FracW - Step;
  localparam logic [RW-1:0] Factor = ExpTab[Step-1];

  logic        v_q;
  logic        en;
  logic [63:0] prod;
  grg_exp_t    d, q;

  assign en         = !v_q || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    prod = 64'(in_data_i.r) * 64'(Factor);
    d    = in_data_i;
    if (in_data_i.f[BitIdx]) d.r = prod[62:31];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= 1'b0;
    else if (en) v_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) q <= d;
  end

  assign out_valid_o = v_q;
  assign out_data_o  = q;
endmodule
`default_nettype wire

>>> rtl/core/grg_scale.sv
// Output stage: scale by 65535, round at the 2^k shift, clamp; holds the output register.
`default_nettype none
module grg_scale (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  input  wire grg_pkg::grg_exp_t        in_data_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  output logic [grg_pkg::ValW-1:0]      out_val_o,
  input  wire logic                     out_ready_i
);
  import grg_pkg::*;

  logic            v_q;
  logic            en;
  logic [47:0]     num;
  logic [47:0]     shifted;
  logic [ValW-1:0] val_d, val_q;

  assign en         = !v_q || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    num     = (48'(in_data_i.r) << 16) - 48'(in_data_i.r)
              + (48'(1) << (6'd30 + 6'(in_data_i.k)));
    shifted = num >> (6'd31 + 6'(in_data_i.k));
    if (in_data_i.sat) val_d = '1;
    else if (in_data_i.zero) val_d = '0;
    else if (shifted[47:ValW] != '0) val_d = '1;
    else val_d = shifted[ValW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= 1'b0;
    else if (en) v_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) val_q <= val_d;
  end

  assign out_valid_o = v_q;
  assign out_val_o   = val_q;
endmodule
`default_nettype wire

>>> rtl/core/gamma_ramp_entry_generator_top.sv
// Gamma ramp entry generator: power-law ramp value per entry index.
// Each request on the slave stream carries an entry index i; the block returns
// round(((i+1)/RAMP_ENTRIES)^e * 65535) with e = (640 - gamma_setting)/512, computed as
// exp2(e * log2(base)) in fixed point. It takes one request per cycle unless the output stalls.
// The pipeline has three front stages (log2 table, exponent multiply, split), 32 stages of the
// exp2 product chain, one 32x32 multiply each, and the output register. Every stage stalls
// on its own, so bubbles close up under backpressure. gamma_setting is written through
// cfg_we_i/cfg_wdata_i and must only change while no request is in flight.
`default_nettype none
module gamma_ramp_entry_generator_top #(
  parameter int unsigned RAMP_ENTRIES = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [9:0]  cfg_wdata_i,    // gamma_setting
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] entry_index
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // [15:0] ramp_value
);
  import grg_pkg::*;

  logic [GammaW-1:0] gamma_q;

  logic     vld [ExpSteps+1];
  grg_exp_t dat [ExpSteps+1];
  logic     rdy [ExpSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) gamma_q <= GammaReset;
    else if (cfg_we_i) gamma_q <= cfg_wdata_i;
  end

  grg_front #(
    .RampEntries(RAMP_ENTRIES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .gamma_i    (gamma_q),
    .in_valid_i (s_axis_tvalid),
    .in_idx_i   (s_axis_tdata),
    .in_ready_o (s_axis_tready),
    .out_valid_o(vld[0]),
    .out_data_o (dat[0]),
    .out_ready_i(rdy[0])
  );

  for (genvar s = 0; s < ExpSteps; s++) begin : g_exp
    grg_exp_step #(
      .Step(s + 1)
    ) u_step (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (vld[s]),
      .in_data_i  (dat[s]),
      .in_ready_o (rdy[s]),
      .out_valid_o(vld[s+1]),
      .out_data_o (dat[s+1]),
      .out_ready_i(rdy[s+1])
    );
  end

  grg_scale u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (vld[ExpSteps]),
    .in_data_i  (dat[ExpSteps]),
    .in_ready_o (rdy[ExpSteps]),
    .out_valid_o(m_axis_tvalid),
    .out_val_o  (m_axis_tdata),
    .out_ready_i(m_axis_tready)
  );
endmodule
`default_nettype wire

>>> rtl/core/grg_checker.sv
// Port-level checker for the gamma ramp entry generator, bound to the top level.
`default_nettype none
`include "gamma_ramp_entry_generator_top_macros.svh"
module grg_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);
  localparam logic [5:0] Depth = 6'd36;

  logic       in_acc, out_acc;
  logic [5:0] cnt_d, cnt_q;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) cnt_d = cnt_q + 6'd1;
    else if (out_acc && !in_acc) cnt_d = cnt_q - 6'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end

  `GRG_ASSERT(a_no_phantom, m_axis_tvalid |-> (cnt_q != 6'd0), "result without request in flight")
  `GRG_ASSERT(a_depth, cnt_q <= Depth, "more requests in flight than pipeline stages")
  `GRG_ASSERT_HOLD(a_valid_hold, m_axis_tvalid, "output valid dropped while stalled")
  `GRG_ASSERT_HOLD(a_data_hold, m_axis_tdata, "output data changed while stalled")
endmodule

bind gamma_ramp_entry_generator_top grg_checker u_grg_checker (.*);
`default_nettype wire

>>> sim/tb_gamma_ramp_entry_generator_top.sv
// Testbench for the gamma ramp entry generator: directed table, random requests, scoreboard.
`default_nettype none
module tb_gamma_ramp_entry_generator_top;
  import grg_pkg::*;

  localparam int unsigned RampEntries = 256;
  localparam int unsigned StallLimit  = 20000;
  localparam int unsigned Latency     = 36;
  localparam logic [15:0] FullScale   = 16'hFFFF;
  localparam int unsigned NoCheck     = 32'hFFFF_FFFF;

  typedef struct {
    logic [7:0] idx;
    int unsigned want;  // typed-in value, or NoCheck for predictor only
  } ramp_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [9:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  logic [9:0]  gamma_q = GammaReset;
  logic [15:0] ramp_q[$];
  int unsigned mismatch_cnt = 0;
  int unsigned idle_cnt = 0;
  bit          calm = 1'b0;  // no idling on either side

  gamma_ramp_entry_generator_top #(.RAMP_ENTRIES(RampEntries)) dut (.*);

  always #6 clk_i = ~clk_i;

  function automatic logic [63:0] int_sqrt(input logic [63:0] a);
    logic [63:0] rem, r, b;
    rem = a;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > rem && b != 0) b = b >> 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint log2_fix(input longint unsigned v);
    int unsigned k;
    logic [63:0] x;
    longint unsigned frac;
    k = 0;
    frac = 0;
    if (v == 0) return 0;
    while (k < 30 && (v >> (k + 1)) != 0) k++;
    x = v << (31 - k);
    for (int j = 31; j >= 0; j--) begin
      x = (x * x) >> 31;
      if (x >= 64'h1_0000_0000) begin
        x = x >> 1;
        frac |= 64'd1 << j;
      end
    end
    return longint'((64'(k) << 32) + frac);
  endfunction

  function automatic logic [15:0] ramp_level(input logic [7:0] idx, input logic [9:0] g);
    longint lg, y;
    logic [63:0] ny, k, f, r, t, v;
    lg = log2_fix(64'(idx) + 1) - log2_fix(RampEntries);
    y = (640 - longint'(g)) * lg;
    if (y >= 0) return FullScale;
    ny = -y;
    k = ny >> 41;
    if (k > 16) return 16'd0;
    f = (ny >> 9) & 64'hFFFF_FFFF;
    r = 64'h8000_0000;
    t = 64'h4000_0000;
    for (int j = 1; j <= 32; j++) begin
      t = int_sqrt(t << 31);
      if ((f >> (32 - j)) & 1) r = (r * t) >> 31;
    end
    v = (r * 65535 + (64'd1 << (30 + k))) >> (31 + k);
    return (v > 65535) ? FullScale : v[15:0];
  endfunction

  // Sender: one request, idling at random unless calm. Valid stays up after
  // the request so the next one can follow without a gap.
  task automatic send_entry(input logic [7:0] idx);
    while (!calm && $urandom_range(99) < 21) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= idx;
    do @(posedge clk_i); while (!s_axis_tready);
    ramp_q = {ramp_q, ramp_level(idx, gamma_q)};
    @(negedge clk_i);
  endtask

  task automatic drain_and_set(input logic [9:0] g);
    s_axis_tvalid <= 1'b0;
    while (ramp_q.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= g;
    gamma_q = g;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Receiver with random stalls.
  always @(negedge clk_i)
    if (rst_ni) m_axis_tready <= calm || ($urandom_range(99) >= 21);

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cnt <= 0;
      else
        idle_cnt <= idle_cnt + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        if (ramp_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("unexpected ramp_value %0d", m_axis_tdata);
        end else begin
          logic [15:0] want;
          want = ramp_q.pop_front();
          if (m_axis_tdata !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("ramp_value mismatch: expected %0d, got %0d", want, m_axis_tdata);
          end
        end
      end
    end
  end

  always @(posedge clk_i)
    if (idle_cnt >= StallLimit) begin
      $display("tb_gamma_ramp_entry_generator_top: done, errors");
      $finish;
    end

  initial begin
    ramp_row_t table_rows[$];
    logic [9:0] settings[6];
    logic [15:0] lvl;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset gamma: top entry is exactly one; low entries nonzero
    table_rows = '{'{8'hFF, 65535}, '{8'h00, NoCheck}, '{8'h01, NoCheck},
                   '{8'h7F, NoCheck}, '{8'hAA, NoCheck}, '{8'h55, NoCheck},
                   '{8'hFE, NoCheck}, '{8'h0F, NoCheck}};
    foreach (table_rows[n]) begin
      lvl = ramp_level(table_rows[n].idx, gamma_q);
      if (table_rows[n].want != NoCheck && lvl != table_rows[n].want[15:0]) begin
        mismatch_cnt++;
        $display("predictor disagrees on entry %0d", table_rows[n].idx);
      end
      send_entry(table_rows[n].idx);
    end

    // g above 640 (here 1023) gives a negative exponent -> full scale; g=640 would give exponent zero
    drain_and_set(10'd1023);
    send_entry(8'h00);
    send_entry(8'h80);
    drain_and_set(10'd0);  // steepest curve (largest exponent)
    send_entry(8'h00);
    send_entry(8'h03);
    send_entry(8'hFF);
    drain_and_set(10'd512);
    send_entry(8'h00);
    send_entry(8'hFF);
    drain_and_set(10'd513);
    send_entry(8'h00);

    settings = '{10'd128, 10'd0, 10'd512, 10'd256, 10'd1023, 10'd700};
    foreach (settings[p]) begin
      drain_and_set(p == 0 ? settings[p] : 10'($urandom_range(0, 1) ? settings[p]
                                                    : $urandom_range(0, 1023)));
      calm = (p == 3);
      repeat (300) send_entry($urandom_range(0, 255));
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (ramp_q.size() != 0) @(negedge clk_i);
    repeat (Latency + 10) @(negedge clk_i);
    if (mismatch_cnt == 0)
      $display("tb_gamma_ramp_entry_generator_top: done, clean");
    else
      $display("tb_gamma_ramp_entry_generator_top: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
